@@ rtl/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg
// Types and codes shared by the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int REC_W = 41;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] height;   // unsigned Q8.8
    logic [7:0]  kind;
    logic        friendly;
  } rec_t;

  typedef enum logic [3:0] {
    CMD_CLEAR       = 4'd0,
    CMD_INS_AT      = 4'd1,
    CMD_INS_FIRST   = 4'd2,
    CMD_INS_LAST    = 4'd3,
    CMD_DEL_AT      = 4'd4,
    CMD_DEL_FIRST   = 4'd5,
    CMD_DEL_LAST    = 4'd6,
    CMD_READ        = 4'd7,
    CMD_WRITE       = 4'd8,
    CMD_FIND        = 4'd9,
    CMD_PURGE       = 4'd10,
    CMD_BY_HEIGHT   = 4'd11,
    CMD_BY_TYPE     = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_INDEX = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_FULL      = 3'd3,
    STS_NO_MATCH  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,   // purge first pass: count the records that stay
    S_WALK,
    S_EMIT
  } state_t;

endpackage

@@ rtl/oale_ram.sv @@
// ----------------------------------------------------------------------------
// oale_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oale_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ordered_array_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Ordered record list held in one RAM; commands walk the list one entry per
// cycle through the RAM read port, shifting or compacting through the write port.
// ----------------------------------------------------------------------------
// Errors, clear, write and insert_last skip the walk and go to the result register.
// Walks (insert, delete, read, find, listings) visit at most the entry count of
// entries; purge walks the list twice, first counting the records that stay.
// One command at a time; a listing stalls while the result register is full.
// Reset clears the entry count and control state; the RAM is not cleared.
module ordered_array_list_engine_unit
  import oale_pkg::*;
#(
  parameter int CAPACITY_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [5:0]  position,
  input  logic [15:0] search_id,
  input  logic [15:0] rec_id,
  input  logic [15:0] rec_height,
  input  logic [7:0]  rec_kind,
  input  logic        rec_friendly,
  input  logic [15:0] height_floor,
  input  logic [7:0]  wanted_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  out_position,
  output logic [15:0] out_id,
  output logic [15:0] out_height,
  output logic [7:0]  out_kind,
  output logic        out_friendly,
  output logic        found,
  output logic [6:0]  entry_count,
  output logic        last
);

  localparam int IW = $clog2(CAPACITY_MAX);
  localparam int CW = $clog2(CAPACITY_MAX + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY_MAX);

  state_t        state, state_next;
  cmd_t          op, in_cmd;
  logic [IW-1:0] pos_r;
  rec_t          nrec;
  logic [15:0]   sid;
  logic [15:0]   floor_h;
  logic [7:0]    want;
  logic [IW-1:0] rptr, rend, didx;
  logic          rdown, rdone, dv;
  logic [CW-1:0] keep, count, cnt_new;
  logic          wr_rec;
  logic          pend_v;
  status_t       res_status;
  logic [5:0]    res_pos;
  rec_t          res_rec;
  logic          res_found;

  // decode
  status_t       dec_status;
  state_t        dec_state;
  logic [5:0]    dec_pos;
  logic [IW-1:0] dec_idx, dec_start, dec_end;
  logic          dec_down, dec_wr;
  logic [CW-1:0] dec_cnt;
  logic [6:0]    cnt7, pos7, acc7;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] ins_idx, acc_idx;

  // walk control
  rec_t          d;
  logic          walking, is_hit, hit, need_push, oslot, stall, proc, issue;
  logic          last_proc, find_stop, emit_go, push;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [REC_W-1:0] ram_rdata;

  oale_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rptr),
    .rdata (ram_rdata)
  );

  assign d        = rec_t'(ram_rdata);
  assign in_ready = (state == S_IDLE);
  assign in_cmd   = cmd_t'(cmd);
  assign cnt7     = 7'(count);
  assign pos7     = {1'b0, position};
  assign cnt_m1   = count - CW'(1);

  always_comb begin
    if (in_cmd == CMD_INS_FIRST) begin
      ins_idx = '0;
    end else if (in_cmd == CMD_INS_LAST) begin
      ins_idx = count[IW-1:0];
    end else begin
      ins_idx = position[IW-1:0];
    end
    if (in_cmd == CMD_DEL_FIRST) begin
      acc7 = '0;
    end else if (in_cmd == CMD_DEL_LAST) begin
      acc7 = cnt7 - 7'd1;
    end else begin
      acc7 = pos7;
    end
    acc_idx = acc7[IW-1:0];
  end

  // command decode at acceptance
  always_comb begin
    dec_state  = S_EMIT;
    dec_status = STS_OK;
    dec_pos    = '0;
    dec_idx    = '0;
    dec_start  = '0;
    dec_end    = cnt_m1[IW-1:0];
    dec_down   = 1'b0;
    dec_wr     = 1'b0;
    dec_cnt    = count;
    unique case (in_cmd)
      CMD_CLEAR: begin
        dec_cnt = '0;
      end
      CMD_INS_AT, CMD_INS_FIRST, CMD_INS_LAST: begin
        if (count == CAP) begin
          dec_status = STS_FULL;
        end else if (in_cmd == CMD_INS_AT && pos7 >= cnt7) begin
          dec_status = STS_BAD_INDEX;
        end else begin
          dec_idx = ins_idx;
          dec_pos = 6'(ins_idx);
          dec_wr  = 1'b1;
          dec_cnt = count + CW'(1);
          if (CW'(ins_idx) != count) begin
            // shift the tail up, from the end back to the insert point
            dec_state = S_WALK;
            dec_start = cnt_m1[IW-1:0];
            dec_end   = ins_idx;
            dec_down  = 1'b1;
          end
        end
      end
      CMD_DEL_AT, CMD_DEL_FIRST, CMD_DEL_LAST, CMD_READ, CMD_WRITE: begin
        if (count == '0) begin
          dec_status = STS_EMPTY;
        end else if (acc7 >= cnt7) begin
          dec_status = STS_BAD_INDEX;
        end else begin
          dec_idx = acc_idx;
          if (in_cmd == CMD_WRITE) begin
            dec_wr  = 1'b1;
            dec_pos = acc7[5:0];
          end else if (in_cmd == CMD_READ) begin
            dec_state = S_WALK;
            dec_start = acc_idx;
            dec_end   = acc_idx;
          end else begin
            dec_state = S_WALK;
            dec_start = acc_idx;
            dec_cnt   = cnt_m1;
          end
        end
      end
      CMD_FIND: begin
        dec_status = STS_NO_MATCH;
        if (count != '0) begin
          dec_state = S_WALK;
        end
      end
      CMD_PURGE: begin
        if (count == '0) begin
          dec_status = STS_EMPTY;
        end else begin
          dec_status = STS_NO_MATCH;
          dec_state  = S_COUNT;
        end
      end
      CMD_BY_HEIGHT, CMD_BY_TYPE: begin
        if (count == '0) begin
          dec_status = STS_EMPTY;
        end else begin
          dec_status = STS_NO_MATCH;
          dec_state  = S_WALK;
        end
      end
      default: begin
      end
    endcase
  end

  // walk step: dv marks RAM read data for entry didx
  always_comb begin
    unique case (op)
      CMD_READ:                                is_hit = 1'b1;
      CMD_DEL_AT, CMD_DEL_FIRST, CMD_DEL_LAST: is_hit = (didx == pos_r);
      CMD_FIND:                                is_hit = (d.id == sid);
      CMD_PURGE:                               is_hit = !d.friendly;
      CMD_BY_HEIGHT:                           is_hit = (d.height >= floor_h);
      CMD_BY_TYPE:                             is_hit = (d.kind == want);
      default:                                 is_hit = 1'b0;
    endcase
  end

  assign walking   = (state == S_WALK) || (state == S_COUNT);
  assign hit       = dv && (state == S_WALK) && is_hit;
  // a held hit goes out only once the next one shows up; the final one is last
  assign need_push = hit && pend_v;
  assign oslot     = !out_valid || out_ready;
  assign stall     = need_push && !oslot;
  assign proc      = dv && !stall;
  assign issue     = walking && !rdone && !stall;
  assign last_proc = proc && (didx == rend);
  assign find_stop = proc && hit && (op == CMD_FIND);
  assign emit_go   = (state == S_EMIT) && oslot;
  assign push      = (proc && need_push) || emit_go;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = nrec;
    if (emit_go) begin
      ram_we = wr_rec;
    end else if (proc && state == S_WALK) begin
      ram_wdata = d;
      unique case (op)
        CMD_INS_AT, CMD_INS_FIRST, CMD_INS_LAST: begin
          ram_we    = 1'b1;
          ram_waddr = didx + IW'(1);
        end
        CMD_DEL_AT, CMD_DEL_FIRST, CMD_DEL_LAST: begin
          ram_we    = (didx != pos_r);
          ram_waddr = didx - IW'(1);
        end
        CMD_PURGE: begin
          ram_we    = d.friendly;
          ram_waddr = keep[IW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = dec_state;
        end
      end
      S_COUNT: begin
        if (last_proc) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (find_stop || last_proc) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (oslot) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dv        <= 1'b0;
      rdone     <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid) begin
        rdone  <= 1'b0;
        pend_v <= 1'b0;
        dv     <= 1'b0;
      end
      if (issue) begin
        dv <= 1'b1;
        if (rptr == rend) begin
          rdone <= 1'b1;
        end
      end else if (proc) begin
        dv <= 1'b0;
      end
      if (hit && proc) begin
        pend_v <= 1'b1;
      end
      if (state == S_COUNT && last_proc) begin
        rdone <= 1'b0;
        dv    <= 1'b0;
      end
      if (state == S_WALK && (find_stop || last_proc)) begin
        dv <= 1'b0;
      end
      if (emit_go) begin
        count <= cnt_new;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op         <= in_cmd;
      pos_r      <= dec_idx;
      nrec       <= '{id: rec_id, height: rec_height, kind: rec_kind,
                      friendly: rec_friendly};
      sid        <= search_id;
      floor_h    <= height_floor;
      want       <= wanted_kind;
      rptr       <= dec_start;
      rend       <= dec_end;
      rdown      <= dec_down;
      wr_rec     <= dec_wr;
      cnt_new    <= dec_cnt;
      keep       <= '0;
      res_status <= dec_status;
      res_pos    <= dec_pos;
      res_rec    <= '0;
      res_found  <= 1'b0;
    end
    if (issue) begin
      rptr <= rdown ? rptr - IW'(1) : rptr + IW'(1);
      didx <= rptr;
    end
    if (proc && d.friendly && (state == S_COUNT || op == CMD_PURGE)) begin
      keep <= keep + CW'(1);
    end
    if (state == S_COUNT && last_proc) begin
      cnt_new <= keep + CW'(d.friendly);
      keep    <= '0;
      rptr    <= '0;
    end
    if (hit && proc) begin
      res_rec    <= d;
      res_pos    <= 6'(didx);
      res_status <= STS_OK;
      res_found  <= 1'b1;
    end
    if (push) begin
      status       <= res_status;
      out_position <= res_pos;
      out_id       <= res_rec.id;
      out_height   <= res_rec.height;
      out_kind     <= res_rec.kind;
      out_friendly <= res_rec.friendly;
      found        <= res_found;
      entry_count  <= 7'(cnt_new);
      last         <= emit_go;
    end
  end

  // ---------------------------------------------------------------- checks
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (rst)
    (ram_we && issue) |-> (ram_waddr != rptr))
    else $error("RAM read and write hit the same entry in one cycle");

  a_dv_only_walking: assert property (@(posedge clk) disable iff (rst)
    dv |-> (state == S_WALK || state == S_COUNT))
    else $error("read data pending outside a walk");

  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (count == $past(cnt_new)))
    else $error("entry count not committed at final result");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && op == CMD_PURGE && dv) |-> (keep <= CW'(didx)))
    else $error("purge write pointer ran ahead of read pointer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count <= CAP))
    else $error("entry count above capacity");

endmodule
